>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge out of reset
`define TMG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// plain invariant out of reset
`define TMG_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

>>> design/tmg_pkg.sv
`timescale 1ns / 1ps
package tmg_pkg;

  localparam int FRAC_BITS = 24;
  localparam int IN_WIDTH  = 40;
  localparam int MAG_WIDTH = IN_WIDTH - 1;
  localparam int BYTE_W    = 8;
  localparam int NUM_LEVELS = 1 << BYTE_W;
  localparam int NUM_CH    = 3;
  localparam int WIDE_W    = 320;

  typedef logic [IN_WIDTH-1:0] thr_arr_t [NUM_LEVELS];

  // word handed from cell to cell: clamped magnitudes and partial bytes
  typedef struct packed {
    logic [NUM_CH-1:0][MAG_WIDTH-1:0] x;
    logic [NUM_CH-1:0][BYTE_W-1:0]    lo;
  } tmg_word_t;

  // smallest code x with x^5 * 510^11 >= (2b-1)^11 * (2^F + x)^5,
  // or 2^MAG_WIDTH where no code of the input range reaches it
  function automatic thr_arr_t build_thresh();
    thr_arr_t            t;
    logic [WIDE_W-1:0]   k;
    logic [WIDE_W-1:0]   lhs;
    logic [WIDE_W-1:0]   rhs;
    logic [WIDE_W-1:0]   d;
    logic [WIDE_W-1:0]   base;
    logic [IN_WIDTH:0]   lo;
    logic [IN_WIDTH:0]   hi;
    logic [IN_WIDTH:0]   mid;
    k = WIDE_W'(1);
    for (int i = 0; i < 11; i++) k = k * WIDE_W'(510);
    t[0] = '0;
    for (int b = 1; b < NUM_LEVELS; b++) begin
      lo = (IN_WIDTH+1)'(1);
      hi = (IN_WIDTH+1)'(1) << MAG_WIDTH;
      for (int s = 0; s <= IN_WIDTH; s++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          lhs = WIDE_W'(1);
          d   = WIDE_W'(1);
          base = (WIDE_W'(1) << FRAC_BITS) + WIDE_W'(mid);
          for (int i = 0; i < 5; i++) begin
            lhs = lhs * WIDE_W'(mid);
            d   = d * base;
          end
          lhs = lhs * k;
          rhs = d;
          for (int i = 0; i < 11; i++) rhs = rhs * WIDE_W'(2 * b - 1);
          if (lhs >= rhs) hi = mid;
          else lo = mid + 1'b1;
        end
      end
      t[b] = IN_WIDTH'(lo);
    end
    return t;
  endfunction

  localparam thr_arr_t THRESH = build_thresh();

endpackage

>>> design/tmg_cell.sv
`timescale 1ns / 1ps
module tmg_cell import tmg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BYTE_W-1:0]   step_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  tmg_word_t           word_i,
  output logic                valid_o,
  input  logic                ready_i,
  output tmg_word_t           word_o
);

  logic      valid_q, valid_d;
  tmg_word_t word_q, word_d;
  logic      load;

  // stage accepts when empty or when its word moves on
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // one search step per lane: try setting this cell's bit
  always_comb begin
    logic [BYTE_W-1:0] mid;
    word_d = word_i;
    for (int c = 0; c < NUM_CH; c++) begin
      mid = word_i.lo[c] | step_i;
      if ({1'b0, word_i.x[c]} >= THRESH[mid]) word_d.lo[c] = mid;
    end
  end

  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> design/tone_map_gamma_to_byte.sv
`timescale 1ns / 1ps
// tone_map_gamma_to_byte: linear radiance pixel to display bytes.
// Input channel: in_valid_i / in_ready_o carry one pixel word of three
// signed 40-bit fixed-point radiance values (24 fraction bits).
// Output channel: out_valid_o / out_ready_i carry the three display bytes.
// Each channel is clamped at zero, tone mapped as x/(1+x), gamma encoded
// with exponent 1/2.2 and rounded to 0..255; large values saturate at 255.
// The cell row is the pipeline: 8 cells, each deciding one bit of the
// byte by comparing against a constant threshold table, MSB first.
// Throughput is one pixel per cycle while out_ready_i is high.
// The last cell's register is the output register.
// When the receiver stalls, words pile up cell by cell and empty cells
// still take new words; in_ready_o drops only when all cells hold words.
// Reset empties every cell; no word is delivered until one is taken in.
`include "assert_macros.svh"
module tone_map_gamma_to_byte import tmg_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [IN_WIDTH-1:0] red_in_i,
  input  logic signed [IN_WIDTH-1:0] green_in_i,
  input  logic signed [IN_WIDTH-1:0] blue_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [BYTE_W-1:0]          red_byte_o,
  output logic [BYTE_W-1:0]          green_byte_o,
  output logic [BYTE_W-1:0]          blue_byte_o
);

  logic      [BYTE_W:0] valid_w;
  logic      [BYTE_W:0] ready_w;
  tmg_word_t            word_w [BYTE_W+1];
  tmg_word_t            word_in;

  // clamp negative radiance to zero
  function automatic logic [MAG_WIDTH-1:0] clamp(input logic [IN_WIDTH-1:0] v);
    return v[IN_WIDTH-1] ? '0 : v[MAG_WIDTH-1:0];
  endfunction

  always_comb begin
    word_in.x[0] = clamp(red_in_i);
    word_in.x[1] = clamp(green_in_i);
    word_in.x[2] = clamp(blue_in_i);
    word_in.lo   = '0;
  end

  assign word_w[0]  = word_in;
  assign valid_w[0] = in_valid_i;
  assign in_ready_o = ready_w[0];

  // row of cells, cell k decides byte bit BYTE_W-1-k
  for (genvar k = 0; k < BYTE_W; k++) begin : g_cell
    tmg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (BYTE_W'(1) << (BYTE_W - 1 - k)),
      .valid_i (valid_w[k]),
      .ready_o (ready_w[k]),
      .word_i  (word_w[k]),
      .valid_o (valid_w[k+1]),
      .ready_i (ready_w[k+1]),
      .word_o  (word_w[k+1])
    );
  end

  assign ready_w[BYTE_W] = out_ready_i;
  assign out_valid_o     = valid_w[BYTE_W];
  assign red_byte_o      = word_w[BYTE_W].lo[0];
  assign green_byte_o    = word_w[BYTE_W].lo[1];
  assign blue_byte_o     = word_w[BYTE_W].lo[2];

  // first cell only ever sets the top bit
  `TMG_ASSERT_IMP(a_first_cell_bits, valid_w[1], word_w[1].lo[0][BYTE_W-2:0] == '0, "cell 0 set a low bit")
  // delivered byte has its threshold reached
  `TMG_ASSERT_IMP(a_out_low_bound, out_valid_o, {1'b0, word_w[BYTE_W].x[0]} >= THRESH[red_byte_o], "red byte above its threshold")
  // next threshold not reached unless saturated
  `TMG_ASSERT_IMP(a_out_high_bound, out_valid_o && (red_byte_o != '1), {1'b0, word_w[BYTE_W].x[0]} < THRESH[red_byte_o + 1'b1], "red byte below its threshold")
  // zero magnitude gives a zero byte
  `TMG_ASSERT_IMP(a_zero_in, out_valid_o && (word_w[BYTE_W].x[1] == '0), green_byte_o == '0, "zero input gave nonzero byte")

endmodule
